/* hw/rtl/fmpl_pkg.sv */
// ----------------------------------------------------------------------------
// fmpl_pkg: shared constants and table functions
// Widths, reset value of the gain and the cos/sin table generator used by the
// frequency modulator.
// ----------------------------------------------------------------------------
package fmpl_pkg;

    localparam int TABLE_BITS      = 10;
    localparam int PHASE_BITS      = 16;
    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_SAMPLE_BITS = 24;

    localparam int              GAIN_W     = 17;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'h10000;

    // 2*pi in Q48
    localparam logic [63:0] TWO_PI_Q48 = 64'h0006_487E_D511_0B46;
    localparam logic [63:0] Q30_ONE    = 64'h0000_0000_4000_0000;
    localparam int          TAYLOR_TERMS = 20;

    // restoring long division, only evaluated while the table is built
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q30 value to Q1.(sb-1), clamped at zero, rounded half up, +1 saturated
    function automatic logic signed [63:0] q30_to_out(input logic signed [63:0] v,
                                                      input int sb);
        logic [63:0]        u;
        logic signed [63:0] maxv;
        int                 sh;
        sh   = 31 - sb;
        maxv = (64'sd1 <<< (sb - 1)) - 64'sd1;
        u    = (v < 0) ? 64'd0 : 64'(v);
        u    = (u + (64'd1 << (sh - 1))) >> sh;
        if ($signed(u) > maxv)
            u = 64'(maxv);
        return $signed(u);
    endfunction

    // one table entry: cos in the upper half, sin in the lower half,
    // each half MAX_SAMPLE_BITS wide with the sample in its low sb bits
    function automatic logic [2*MAX_SAMPLE_BITS-1:0] sincos_entry(input int tb,
                                                                 input int sb,
                                                                 input int idx);
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        ts;
        logic [63:0]        tc;
        logic [63:0]        div_s;
        logic [63:0]        div_c;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [63:0] co;
        logic signed [63:0] so;
        logic signed [63:0] cos_v;
        logic signed [63:0] sin_v;
        logic [1:0]         quad;
        int                 tsh;
        quad = 2'(idx >> (tb - 2));
        r    = 64'(idx) & ((64'd1 << (tb - 2)) - 64'd1);
        tsh  = tb + 18;
        x    = (r * TWO_PI_Q48 + (64'd1 << (tsh - 1))) >> tsh;
        x2   = (x * x) >> 30;
        ts   = x;
        tc   = Q30_ONE;
        s    = $signed(x);
        c    = $signed(Q30_ONE);
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            div_s = 64'((2 * k) * (2 * k + 1));
            div_c = 64'((2 * k - 1) * (2 * k));
            ts    = udiv64((ts * x2) >> 30, div_s);
            tc    = udiv64((tc * x2) >> 30, div_c);
            if ((k % 2) == 1)
            begin
                s = s - $signed(ts);
                c = c - $signed(tc);
            end
            else
            begin
                s = s + $signed(ts);
                c = c + $signed(tc);
            end
        end
        co = q30_to_out(c, sb);
        so = q30_to_out(s, sb);
        case (quad)
            2'd0:
            begin
                cos_v = co;
                sin_v = so;
            end
            2'd1:
            begin
                cos_v = -so;
                sin_v = co;
            end
            2'd2:
            begin
                cos_v = -co;
                sin_v = -so;
            end
            default:
            begin
                cos_v = so;
                sin_v = -co;
            end
        endcase
        return {MAX_SAMPLE_BITS'(cos_v), MAX_SAMPLE_BITS'(sin_v)};
    endfunction

endpackage

/* hw/rtl/fmpl_if.sv */
// ----------------------------------------------------------------------------
// fmpl_if: stream channels of the frequency modulator
// Message sample channel and complex output sample channel, valid/ready.
// ----------------------------------------------------------------------------
interface fmpl_msg_if #(
    parameter int SAMPLE_BITS = fmpl_pkg::SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] message;

    modport source (output valid, output message, input ready);
    modport sink   (input valid, input message, output ready);
endinterface

interface fmpl_iq_if #(
    parameter int SAMPLE_BITS = fmpl_pkg::SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_real;
    logic signed [SAMPLE_BITS-1:0] out_imag;

    modport source (output valid, output out_real, output out_imag, input ready);
    modport sink   (input valid, input out_real, input out_imag, output ready);
endinterface

/* hw/rtl/fmpl_step_gen.sv */
// ----------------------------------------------------------------------------
// fmpl_step_gen: phase step from message sample
// Registers the message, then forms round(gain * m / 2^(SAMPLE_BITS-1)) with
// ties away from zero as a magnitude and a sign.
// ----------------------------------------------------------------------------
module fmpl_step_gen #(
    parameter int SAMPLE_BITS = fmpl_pkg::SAMPLE_BITS,
    parameter int STEP_W      = fmpl_pkg::GAIN_W + 1
) (
    input  logic                          clk,
    input  logic                          msg_load,
    input  logic signed [SAMPLE_BITS-1:0] message,
    input  logic                          step_load,
    input  logic [fmpl_pkg::GAIN_W-1:0]   phase_gain,
    output logic [STEP_W-1:0]             step,
    output logic                          step_neg
);
    localparam int PROD_W = SAMPLE_BITS + fmpl_pkg::GAIN_W;

    logic signed [SAMPLE_BITS-1:0] msg_reg;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W-1:0]             prod_rnd;
    logic [STEP_W-1:0]             step_reg;
    logic [STEP_W-1:0]             step_next;
    logic                          neg_reg;

    // most negative sample wraps to its true magnitude as unsigned
    assign mag       = msg_reg[SAMPLE_BITS-1] ? (~msg_reg + 1'b1) : msg_reg;
    assign prod      = PROD_W'(mag) * PROD_W'(phase_gain);
    assign prod_rnd  = prod + (PROD_W'(1) << (SAMPLE_BITS - 2));
    assign step_next = STEP_W'(prod_rnd >> (SAMPLE_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (msg_load)
        begin
            msg_reg <= message;
        end
        if (step_load)
        begin
            step_reg <= step_next;
            neg_reg  <= msg_reg[SAMPLE_BITS-1];
        end
    end

    assign step     = step_reg;
    assign step_neg = neg_reg;
endmodule

/* hw/rtl/fmpl_phase_acc.sv */
// ----------------------------------------------------------------------------
// fmpl_phase_acc: wrapping phase accumulator
// Adds or subtracts the step modulo 2^PHASE_BITS and rounds the phase to a
// table index, or pads it with zeros when the index is wider than the phase.
// ----------------------------------------------------------------------------
module fmpl_phase_acc #(
    parameter int PHASE_BITS = fmpl_pkg::PHASE_BITS,
    parameter int TABLE_BITS = fmpl_pkg::TABLE_BITS,
    parameter int STEP_W     = fmpl_pkg::GAIN_W + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [STEP_W-1:0]     step,
    input  logic                  step_neg,
    output logic [TABLE_BITS-1:0] idx
);
    localparam int ACC_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
    localparam int SH    = PHASE_BITS - TABLE_BITS;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [ACC_W-1:0]      acc_ext;
    logic [ACC_W-1:0]      step_ext;
    logic [ACC_W-1:0]      sum;

    assign acc_ext    = ACC_W'(phase_reg);
    assign step_ext   = ACC_W'(step);
    assign sum        = step_neg ? (acc_ext - step_ext) : (acc_ext + step_ext);
    assign phase_next = PHASE_BITS'(sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (load)
        begin
            phase_reg <= phase_next;
        end
    end

    // round to nearest table entry, wrapping at the top
    generate
        if (SH > 0)
        begin : g_round
            assign idx = phase_reg[PHASE_BITS-1:SH] + TABLE_BITS'(phase_reg[SH-1]);
        end
        else if (SH == 0)
        begin : g_equal
            assign idx = phase_reg;
        end
        else
        begin : g_widen
            localparam int ZPAD = TABLE_BITS - PHASE_BITS;
            assign idx = {phase_reg, {ZPAD{1'b0}}};
        end
    endgenerate
endmodule

/* hw/rtl/fmpl_sincos_lut.sv */
// ----------------------------------------------------------------------------
// fmpl_sincos_lut: constant cos/sin table with output register
// Table of cos and sin of 2*pi*i/2^TABLE_BITS, looked up and registered.
// ----------------------------------------------------------------------------
module fmpl_sincos_lut #(
    parameter int TABLE_BITS  = fmpl_pkg::TABLE_BITS,
    parameter int SAMPLE_BITS = fmpl_pkg::SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic [TABLE_BITS-1:0]         idx,
    output logic signed [SAMPLE_BITS-1:0] cos_out,
    output logic signed [SAMPLE_BITS-1:0] sin_out
);
    localparam int TAB_LEN = 1 << TABLE_BITS;
    localparam int MSB     = fmpl_pkg::MAX_SAMPLE_BITS;

    logic [2*SAMPLE_BITS-1:0]      lut [TAB_LEN];
    logic signed [SAMPLE_BITS-1:0] cos_reg;
    logic signed [SAMPLE_BITS-1:0] sin_reg;

    generate
        for (genvar gi = 0; gi < TAB_LEN; gi++)
        begin : g_entry
            localparam logic [2*MSB-1:0] ENTRY =
                fmpl_pkg::sincos_entry(TABLE_BITS, SAMPLE_BITS, gi);
            assign lut[gi] = {ENTRY[MSB+SAMPLE_BITS-1:MSB], ENTRY[SAMPLE_BITS-1:0]};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cos_reg <= lut[idx][2*SAMPLE_BITS-1:SAMPLE_BITS];
            sin_reg <= lut[idx][SAMPLE_BITS-1:0];
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
endmodule

/* hw/rtl/fm_modulator_phase_lut_top.sv */
// ----------------------------------------------------------------------------
// fm_modulator_phase_lut_top: frequency modulator with cos/sin table
// Message samples in, complex baseband samples out.
// ----------------------------------------------------------------------------
// Usage:
//   msg  - sink channel, one signed Q1.15 message sample per beat
//   iq   - source channel, one complex sample (out_real = cos, out_imag = sin)
//          per accepted message beat, in order
//   cfg_wr_en / cfg_wr_data - writes phase_gain (phase units per full-scale
//          message); write only while no beat is in flight
// Pipeline: input register, step multiply, phase accumulator, table lookup
//   into the output register.
// Throughput: one beat per cycle while iq does not stall, set by the add loop
//   of the phase accumulator and one table read per cycle.
// Reset clears the phase to zero, sets phase_gain to 65536 and empties the
//   pipeline. When iq stalls, each stage holds once the one after it is full;
//   msg.ready drops only when every stage holds a beat.
// ----------------------------------------------------------------------------
module fm_modulator_phase_lut_top #(
    parameter int TABLE_BITS  = fmpl_pkg::TABLE_BITS,
    parameter int PHASE_BITS  = fmpl_pkg::PHASE_BITS,
    parameter int SAMPLE_BITS = fmpl_pkg::SAMPLE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fmpl_msg_if.sink                    msg,
    fmpl_iq_if.source                   iq,
    input  logic                        cfg_wr_en,
    input  logic [fmpl_pkg::GAIN_W-1:0] cfg_wr_data
);
    localparam int STEP_W = fmpl_pkg::GAIN_W + 1;

    logic [fmpl_pkg::GAIN_W-1:0] phase_gain_reg;
    logic                        s1_valid_reg;
    logic                        s2_valid_reg;
    logic                        s3_valid_reg;
    logic                        out_valid_reg;
    logic                        en1;
    logic                        en2;
    logic                        en3;
    logic                        en4;
    logic                        ph_load;
    logic [STEP_W-1:0]           step;
    logic                        step_neg;
    logic [TABLE_BITS-1:0]       lut_idx;

    // a stage moves when it is empty or the next one moves
    assign en4     = !out_valid_reg || iq.ready;
    assign en3     = !s3_valid_reg || en4;
    assign en2     = !s2_valid_reg || en3;
    assign en1     = !s1_valid_reg || en2;
    assign ph_load = en3 && s2_valid_reg;

    assign msg.ready = en1;
    assign iq.valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_gain_reg <= fmpl_pkg::GAIN_RESET;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                phase_gain_reg <= cfg_wr_data;
            end
            if (en1)
            begin
                s1_valid_reg <= msg.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    fmpl_step_gen #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STEP_W      (STEP_W)
    ) u_step_gen (
        .clk        (clk),
        .msg_load   (en1 && msg.valid),
        .message    (msg.message),
        .step_load  (en2 && s1_valid_reg),
        .phase_gain (phase_gain_reg),
        .step       (step),
        .step_neg   (step_neg)
    );

    fmpl_phase_acc #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS),
        .STEP_W     (STEP_W)
    ) u_phase_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ph_load),
        .step     (step),
        .step_neg (step_neg),
        .idx      (lut_idx)
    );

    fmpl_sincos_lut #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sincos_lut (
        .clk     (clk),
        .load    (en4 && s3_valid_reg),
        .idx     (lut_idx),
        .cos_out (iq.out_real),
        .sin_out (iq.out_imag)
    );

`ifndef SYNTHESIS
    // phase only moves when a step beat enters the accumulator stage
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ph_load |=> $stable(lut_idx))
        else $error("phase index changed without a step beat");

    // an empty input stage never blocks the message channel
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> msg.ready)
        else $error("input stage empty but msg not ready");

    // a result appears only from a looked-up phase
    a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_valid_reg))
        else $error("output valid without a phase beat");

    // a blocked phase beat is not lost
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !en4 |=> s3_valid_reg)
        else $error("phase beat dropped under stall");
`endif
endmodule
